@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition holds whenever a qualifier is high.
`define ASSERT_WHEN(label, clk, rstn, qual, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (qual) |-> (cond)) \
        else $error(msg);

`endif

@@ rtl/ttf_pkg.sv @@
// Shared constants, types and helpers for the Taylor trig function unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttf_pkg;

    // Series and fixed point setup
    localparam int TERMS      = 26;
    localparam int FRAC_BITS  = 16;
    localparam int IP         = 30;
    localparam int ANGLE_FRAC = 16;

    // Port field widths
    localparam int SEL_W       = 3;
    localparam int ANG_W       = 20;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    // Series datapath widths (angle magnitude at most 8.0 rad)
    localparam int TW   = 40;             // one term, Q30
    localparam int X2W  = 37;             // x squared, Q30
    localparam int AW   = 44;             // signed partial sum
    localparam int TH   = 20;             // low half of a term for the split multiply
    localparam int PPW  = (TW - TH) + X2W;
    localparam int SUMW = PPW + TH + 1;

    // Digit-wise division of a term by its constant denominator
    localparam int DIG   = 16;
    localparam int NDIG  = 3;
    localparam int PW    = DIG * NDIG;
    localparam int DW    = 12;            // denominator, at most 50*51
    localparam int SH    = 28;            // reciprocal scale
    localparam int VW    = DW + DIG;
    localparam int MW    = SH;
    localparam int PRW   = VW + MW;
    localparam int TERM_STAGES = 3 + 2 * NDIG;

    // Final quotient
    localparam int MAGW = 32;
    localparam int NW   = MAGW + FRAC_BITS;

    localparam logic [AW-1:0] ONE_Q = AW'(64'd1 << IP);

    // Function selector codes
    localparam logic [SEL_W-1:0] SEL_SIN = 3'd0;
    localparam logic [SEL_W-1:0] SEL_COS = 3'd1;
    localparam logic [SEL_W-1:0] SEL_TAN = 3'd2;
    localparam logic [SEL_W-1:0] SEL_SEC = 3'd3;
    localparam logic [SEL_W-1:0] SEL_COT = 3'd4;
    localparam logic [SEL_W-1:0] SEL_CSC = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd2;

    // One item on its way through the series chain
    typedef struct packed {
        logic                  vld;
        logic [SEL_W-1:0]      sel;
        logic                  neg;
        logic [X2W-1:0]        x2;
        logic [TW-1:0]         t_s;
        logic [TW-1:0]         t_c;
        logic signed [AW-1:0]  acc_s;
        logic signed [AW-1:0]  acc_c;
    } series_t;

    // Control carried along the divider
    typedef struct packed {
        logic vld;
        logic dz;
        logic nneg;
        logic qneg;
    } div_ctl_t;

    // Denominator of term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
    function automatic int term_d(input int k, input bit odd);
        int n;
        n = odd ? 2 * k : 2 * k - 1;
        return n * (n + 1);
    endfunction

    // Magnitude of a partial sum, narrowed to the divider width
    function automatic logic [MAGW-1:0] mag_of(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        m = v[AW-1] ? -v : v;
        return m[MAGW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ttf_front.sv @@
// Input stage: angle magnitude, x and x squared, series seeds.
// Depends on ttf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [ttf_pkg::SEL_W-1:0]     sel,
    input  wire logic [ttf_pkg::ANG_W-1:0]     angle,
    output ttf_pkg::series_t                   out_item
);

    ttf_pkg::series_t item_reg;
    ttf_pkg::series_t item_next;
    logic [ttf_pkg::ANG_W-1:0]   mag;
    logic [2*ttf_pkg::ANG_W-1:0] sq;
    logic [ttf_pkg::TW-1:0]      x;

    // Magnitude of the angle, its square in Q30 and its Q30 form
    always_comb begin
        mag = angle[ttf_pkg::ANG_W-1] ? (~angle + 1'b1) : angle;
        sq  = mag * mag;
        x   = ttf_pkg::TW'(mag) << (ttf_pkg::IP - ttf_pkg::ANGLE_FRAC);
        item_next.vld   = in_vld && (sel <= ttf_pkg::SEL_CSC);
        item_next.sel   = sel;
        item_next.neg   = angle[ttf_pkg::ANG_W-1];
        item_next.x2    = sq[ttf_pkg::X2W+1:2];
        item_next.t_s   = x;
        item_next.t_c   = ttf_pkg::ONE_Q[ttf_pkg::TW-1:0];
        item_next.acc_s = ttf_pkg::AW'(x);
        item_next.acc_c = ttf_pkg::ONE_Q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

`default_nettype wire

@@ rtl/ttf_term.sv @@
// One Taylor term for both sine and cosine: t = floor(t*x2/2^30)/d, acc +/- t.
// Depends on ttf_pkg. Nine register stages.
`timescale 1ns / 1ps
`default_nettype none

module ttf_term (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic [ttf_pkg::DW-1:0]     div_s,
    input  wire logic [ttf_pkg::DW-1:0]     div_c,
    input  wire logic [ttf_pkg::MW-1:0]     rcp_s,
    input  wire logic [ttf_pkg::MW-1:0]     rcp_c,
    input  wire logic                       sub,
    input  ttf_pkg::series_t                in_item,
    output ttf_pkg::series_t                out_item
);

    localparam int NST  = ttf_pkg::TERM_STAGES;
    localparam int DIG  = ttf_pkg::DIG;
    localparam int NDIG = ttf_pkg::NDIG;
    localparam int PW   = ttf_pkg::PW;
    localparam int DW   = ttf_pkg::DW;
    localparam int VW   = ttf_pkg::VW;
    localparam int TW   = ttf_pkg::TW;
    localparam int TH   = ttf_pkg::TH;
    localparam int AW   = ttf_pkg::AW;

    // Stage registers; lane 0 is sine, lane 1 cosine
    ttf_pkg::series_t               base_reg [NST];
    logic [ttf_pkg::PPW-1:0]        pplo_reg [2];
    logic [ttf_pkg::PPW-1:0]        pphi_reg [2];
    logic [PW-1:0]                  p_reg    [2];
    logic [VW-1:0]                  v_reg    [NDIG][2];
    logic [ttf_pkg::PRW-1:0]        prod_reg [NDIG][2];
    logic [PW-1:0]                  pa_reg   [NDIG][2];
    logic [PW-1:0]                  pb_reg   [NDIG][2];
    logic [PW-1:0]                  qa_reg   [NDIG][2];
    logic [PW-1:0]                  qb_reg   [NDIG][2];
    logic [DW-1:0]                  r_reg    [NDIG][2];

    // Next values
    logic [TW-1:0]                  t_in      [2];
    logic [DW-1:0]                  dv        [2];
    logic [ttf_pkg::MW-1:0]         mv        [2];
    logic [ttf_pkg::PPW-1:0]        pplo_next [2];
    logic [ttf_pkg::PPW-1:0]        pphi_next [2];
    logic [ttf_pkg::SUMW-1:0]       sum       [2];
    logic [PW-1:0]                  p_next    [2];
    logic [PW-1:0]                  psrc      [NDIG][2];
    logic [DW-1:0]                  rprev     [NDIG][2];
    logic [PW-1:0]                  qprev     [NDIG][2];
    logic [VW-1:0]                  v_next    [NDIG][2];
    logic [ttf_pkg::PRW-1:0]        prod_next [NDIG][2];
    logic [DIG-1:0]                 q0        [NDIG][2];
    logic [VW-1:0]                  rw        [NDIG][2];
    logic [DIG-1:0]                 qd        [NDIG][2];
    logic [DW-1:0]                  r_next    [NDIG][2];
    logic [PW-1:0]                  qb_next   [NDIG][2];
    logic [TW-1:0]                  t_new     [2];
    ttf_pkg::series_t               fin_next;

    assign t_in[0] = in_item.t_s;
    assign t_in[1] = in_item.t_c;
    assign dv[0]   = div_s;
    assign dv[1]   = div_c;
    assign mv[0]   = rcp_s;
    assign mv[1]   = rcp_c;

    // Split multiply, then recombine and drop 30 fraction bits
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pplo_next[l] = ttf_pkg::PPW'(t_in[l][TH-1:0] * in_item.x2);
            pphi_next[l] = ttf_pkg::PPW'(t_in[l][TW-1:TH] * in_item.x2);
            sum[l]       = (ttf_pkg::SUMW'(pphi_reg[l]) << TH) + ttf_pkg::SUMW'(pplo_reg[l]);
            p_next[l]    = sum[l][ttf_pkg::IP +: PW];
        end
    end

    // Long division by the constant denominator, one 16-bit digit per two stages
    always_comb begin
        for (int g = 0; g < NDIG; g++) begin
            for (int l = 0; l < 2; l++) begin
                psrc[g][l]  = (g == 0) ? p_reg[l] : pb_reg[(g == 0) ? 0 : g - 1][l];
                rprev[g][l] = (g == 0) ? '0 : r_reg[(g == 0) ? 0 : g - 1][l];
                qprev[g][l] = (g == 0) ? '0 : qb_reg[(g == 0) ? 0 : g - 1][l];
                v_next[g][l]    = {rprev[g][l], psrc[g][l][PW-1-DIG*g -: DIG]};
                prod_next[g][l] = v_next[g][l] * mv[l];
                // Estimate is the quotient or one below it
                q0[g][l] = prod_reg[g][l][ttf_pkg::SH +: DIG];
                rw[g][l] = v_reg[g][l] - VW'(q0[g][l] * dv[l]);
                if (rw[g][l] >= VW'(dv[l])) begin
                    qd[g][l]     = q0[g][l] + 1'b1;
                    r_next[g][l] = DW'(rw[g][l] - VW'(dv[l]));
                end else begin
                    qd[g][l]     = q0[g][l];
                    r_next[g][l] = DW'(rw[g][l]);
                end
                qb_next[g][l] = {qa_reg[g][l][PW-DIG-1:0], qd[g][l]};
            end
        end
    end

    // New term goes into the running sums
    always_comb begin
        fin_next = base_reg[NST-2];
        for (int l = 0; l < 2; l++) begin
            t_new[l] = qb_reg[NDIG-1][l][TW-1:0];
        end
        fin_next.t_s   = t_new[0];
        fin_next.t_c   = t_new[1];
        fin_next.acc_s = sub ? base_reg[NST-2].acc_s - AW'(t_new[0])
                             : base_reg[NST-2].acc_s + AW'(t_new[0]);
        fin_next.acc_c = sub ? base_reg[NST-2].acc_c - AW'(t_new[1])
                             : base_reg[NST-2].acc_c + AW'(t_new[1]);
    end

    // Item and valid bits through the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) begin
                base_reg[i].vld <= 1'b0;
            end
        end else if (en) begin
            base_reg[0] <= in_item;
            for (int i = 1; i < NST - 1; i++) begin
                base_reg[i] <= base_reg[i-1];
            end
            base_reg[NST-1] <= fin_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                pplo_reg[l] <= pplo_next[l];
                pphi_reg[l] <= pphi_next[l];
                p_reg[l]    <= p_next[l];
                for (int g = 0; g < NDIG; g++) begin
                    v_reg[g][l]    <= v_next[g][l];
                    prod_reg[g][l] <= prod_next[g][l];
                    pa_reg[g][l]   <= psrc[g][l];
                    qa_reg[g][l]   <= qprev[g][l];
                    pb_reg[g][l]   <= pa_reg[g][l];
                    qb_reg[g][l]   <= qb_next[g][l];
                    r_reg[g][l]    <= r_next[g][l];
                end
            end
        end
    end

    assign out_item = base_reg[NST-1];

endmodule

`default_nettype wire

@@ rtl/ttf_div.sv @@
// Result stage: picks dividend and divisor, restoring divide, saturation.
// Depends on ttf_pkg. Sine and cosine go through as a divide by 1.0.
`timescale 1ns / 1ps
`default_nettype none

module ttf_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  ttf_pkg::series_t                 in_item,
    output logic                             out_vld,
    output logic [ttf_pkg::VAL_W-1:0]        out_value,
    output logic [ttf_pkg::ST_W-1:0]         out_status
);

    localparam int NW   = ttf_pkg::NW;
    localparam int MAGW = ttf_pkg::MAGW;
    localparam int AW   = ttf_pkg::AW;
    localparam int VAL_W = ttf_pkg::VAL_W;

    localparam logic [VAL_W-1:0] MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MAX_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    ttf_pkg::div_ctl_t   ctl_reg [NW+1];
    logic [MAGW-1:0]     rem_reg [NW+1];
    logic [NW-1:0]       nq_reg  [NW+1];
    logic [MAGW-1:0]     den_reg [NW+1];

    logic signed [AW-1:0] s_val;
    logic signed [AW-1:0] n_val;
    logic signed [AW-1:0] d_val;
    ttf_pkg::div_ctl_t    ctl_next;
    logic [MAGW:0]        tmp     [NW];
    logic                 ge      [NW];
    logic [MAGW-1:0]      rem_nxt [NW];
    logic [NW-1:0]        nq_nxt  [NW];

    logic [NW-1:0]        qmag;
    logic                 sat;
    logic [VAL_W-1:0]     mag32;
    logic [VAL_W-1:0]     val_next;
    logic [ttf_pkg::ST_W-1:0] st_next;

    // Operand selection
    always_comb begin
        s_val = in_item.neg ? -in_item.acc_s : in_item.acc_s;
        case (in_item.sel)
            ttf_pkg::SEL_SIN: begin n_val = s_val;          d_val = ttf_pkg::ONE_Q; end
            ttf_pkg::SEL_COS: begin n_val = in_item.acc_c;  d_val = ttf_pkg::ONE_Q; end
            ttf_pkg::SEL_TAN: begin n_val = s_val;          d_val = in_item.acc_c;  end
            ttf_pkg::SEL_SEC: begin n_val = ttf_pkg::ONE_Q; d_val = in_item.acc_c;  end
            ttf_pkg::SEL_COT: begin n_val = in_item.acc_c;  d_val = s_val;          end
            default:          begin n_val = ttf_pkg::ONE_Q; d_val = s_val;          end
        endcase
        ctl_next.vld  = in_item.vld;
        ctl_next.dz   = (d_val == '0);
        ctl_next.nneg = n_val[AW-1];
        ctl_next.qneg = n_val[AW-1] ^ d_val[AW-1];
    end

    // One quotient bit per stage
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            tmp[i] = {rem_reg[i], nq_reg[i][NW-1]};
            ge[i]  = tmp[i] >= {1'b0, den_reg[i]};
            rem_nxt[i] = ge[i] ? MAGW'(tmp[i] - {1'b0, den_reg[i]}) : MAGW'(tmp[i]);
            nq_nxt[i]  = {nq_reg[i][NW-2:0], ge[i]};
        end
    end

    // Saturation and sign
    always_comb begin
        qmag  = nq_reg[NW];
        sat   = ctl_reg[NW].qneg ? (qmag > NW'(MAX_NEG)) : (qmag > NW'(MAX_POS));
        mag32 = sat ? (ctl_reg[NW].qneg ? MAX_NEG : MAX_POS) : qmag[VAL_W-1:0];
        if (ctl_reg[NW].dz) begin
            val_next = ctl_reg[NW].nneg ? MAX_NEG : MAX_POS;
            st_next  = ttf_pkg::ST_DZ;
        end else begin
            val_next = ctl_reg[NW].qneg ? (~mag32 + 1'b1) : mag32;
            st_next  = sat ? ttf_pkg::ST_SAT : ttf_pkg::ST_OK;
        end
    end

    // Control and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NW; i++) begin
                ctl_reg[i].vld <= 1'b0;
            end
            out_vld <= 1'b0;
        end else if (en) begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i <= NW; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            out_vld <= ctl_reg[NW].vld;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= NW'(ttf_pkg::mag_of(n_val)) << ttf_pkg::FRAC_BITS;
            den_reg[0] <= ttf_pkg::mag_of(d_val);
            for (int i = 0; i < NW; i++) begin
                rem_reg[i+1] <= rem_nxt[i];
                nq_reg[i+1]  <= nq_nxt[i];
                den_reg[i+1] <= den_reg[i];
            end
            out_value  <= val_next;
            out_status <= st_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/taylor_trig_function_unit.sv @@
// Top level of the Taylor-series trig function unit.
// Depends on ttf_pkg, ttf_front, ttf_term and ttf_div.
//
//  channel | dir | tdata (low bit up)                  | tuser
//  s_      | in  | angle[19:0] Q3.16, 4 zero bits      | req_type[2:0]
//  m_      | out | value[31:0] Q16.16, status[1:0], 6 zero bits | -
//
// One item enters per cycle unless m_tready stalls the pipeline; it has 1 input
// stage, 25 terms of 9 stages (split multiply, three divide digits, sum), then
// 50 divider stages (operand select, 48 restoring-divide bits, saturate/output).
// Reset is synchronous, active low, and empties all valid bits.
// The whole pipeline holds while a result waits on m_tready; nothing is lost.
// req_type 6 and 7 are accepted and give no result.
`timescale 1ns / 1ps
`default_nettype none

module taylor_trig_function_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ttf_pkg::S_TDATA_W-1:0]     s_tdata,   // angle[19:0], pad
    input  wire logic [ttf_pkg::SEL_W-1:0]         s_tuser,   // req_type[2:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ttf_pkg::M_TDATA_W-1:0]          m_tdata    // value[31:0], status[33:32], pad
);

    localparam int NT = ttf_pkg::TERMS;

    logic                           en;
    ttf_pkg::series_t               chain [NT];
    logic [ttf_pkg::VAL_W-1:0]      value;
    logic [ttf_pkg::ST_W-1:0]       status;

    // Global advance: the pipeline moves when the output register frees up
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ttf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_tvalid),
        .sel      (s_tuser),
        .angle    (s_tdata[ttf_pkg::ANG_W-1:0]),
        .out_item (chain[0])
    );

    // Series terms 1 .. TERMS-1
    for (genvar g = 0; g < NT - 1; g++) begin : g_term
        localparam int K   = g + 1;
        localparam int DSI = ttf_pkg::term_d(K, 1'b1);
        localparam int DCI = ttf_pkg::term_d(K, 1'b0);
        localparam logic [ttf_pkg::DW-1:0] DS = ttf_pkg::DW'(DSI);
        localparam logic [ttf_pkg::DW-1:0] DC = ttf_pkg::DW'(DCI);
        localparam logic [ttf_pkg::MW-1:0] MS = ttf_pkg::MW'((64'd1 << ttf_pkg::SH) / DSI);
        localparam logic [ttf_pkg::MW-1:0] MC = ttf_pkg::MW'((64'd1 << ttf_pkg::SH) / DCI);
        localparam logic SUB = (K % 2) == 1;

        ttf_term u_term (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .div_s    (DS),
            .div_c    (DC),
            .rcp_s    (MS),
            .rcp_c    (MC),
            .sub      (SUB),
            .in_item  (chain[g]),
            .out_item (chain[g+1])
        );
    end

    ttf_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_item    (chain[NT-1]),
        .out_vld    (m_tvalid),
        .out_value  (value),
        .out_status (status)
    );

    assign m_tdata = {{(ttf_pkg::M_TDATA_W - ttf_pkg::VAL_W - ttf_pkg::ST_W){1'b0}},
                      status, value};

endmodule

`default_nettype wire

@@ rtl/ttf_checker.sv @@
// Port-level checks for taylor_trig_function_unit, bound to the top level.
// Depends on ttf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttf_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [ttf_pkg::S_TDATA_W-1:0]     s_tdata,
    input wire logic [ttf_pkg::SEL_W-1:0]         s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [ttf_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [ttf_pkg::ST_W-1:0]  st;
    logic [ttf_pkg::VAL_W-1:0] val;
    logic [5:0]                pad;
    logic                      stalled;
    logic                      flagged;
    logic                      at_limit;

    assign st       = m_tdata[33:32];
    assign val      = m_tdata[31:0];
    assign pad      = m_tdata[39:34];
    assign stalled  = m_tvalid && !m_tready;
    assign flagged  = (st == ttf_pkg::ST_DZ) || (st == ttf_pkg::ST_SAT);
    assign at_limit = (val == 32'h7FFF_FFFF) || (val == 32'h8000_0000);

    // Input is never refused while the output register is free
    `ASSERT_WHEN(a_ready_free, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

    // A waiting result holds still
    `ASSERT_CLK(a_hold, aclk, aresetn, stalled |=> m_tvalid && $stable(m_tdata), "result moved")

    // Status codes above division by zero never appear, padding stays zero
    `ASSERT_WHEN(a_status, aclk, aresetn, m_tvalid, (st <= ttf_pkg::ST_DZ) && (pad == '0), "bad status")

    // Saturated and divide-by-zero results sit on a range limit
    `ASSERT_WHEN(a_limit, aclk, aresetn, m_tvalid && flagged, at_limit, "limit value expected")

    // An offered item carries known selector and angle bits
    `ASSERT_WHEN(a_known, aclk, aresetn, s_tvalid, !$isunknown({s_tuser, s_tdata}), "unknown input")

endmodule

bind taylor_trig_function_unit ttf_checker u_chk (.*);

`default_nettype wire

@@ verif/taylor_trig_function_unit_test.sv @@
// Self-checking testbench for taylor_trig_function_unit: sine, cosine and quotient functions.
// Needs ttf_pkg and the RTL of the block; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module taylor_trig_function_unit_test;
    import ttf_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ST_W-1:0]         status;
    } trig_result_t;

    // Predicts trig results and compares them with what the block returns
    class trig_scoreboard;
        trig_result_t pending[$];
        int errors;
        int n_in;
        int n_out;
        int n_sel[8];

        // Truncated Taylor sum on magnitudes, Q30
        function longint taylor_sum(bit [63:0] start, bit [63:0] x2, bit odd);
            bit [63:0]  term;
            longint     acc;
            bit [127:0] prod;
            bit [63:0]  n;
            bit [63:0]  den;
            term = start;
            acc = start;
            for (int k = 1; k < TERMS; k++) begin
                n = 64'(odd ? 2 * k : 2 * k - 1);
                den = n * (n + 1);
                prod = {64'd0, term} * {64'd0, x2};
                term = prod[IP+63:IP] / den;
                if (k % 2) acc -= term;
                else acc += term;
            end
            return acc;
        endfunction

        function bit [63:0] magnitude(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Signed magnitude to 32 bits with saturation
        function trig_result_t saturate(bit neg, bit [63:0] mag);
            trig_result_t r;
            r.status = ST_OK;
            if (!neg && mag > 64'h7FFF_FFFF) begin
                mag = 64'h7FFF_FFFF;
                r.status = ST_SAT;
            end
            if (neg && mag > 64'h8000_0000) begin
                mag = 64'h8000_0000;
                r.status = ST_SAT;
            end
            r.value = neg ? -mag[31:0] : mag[31:0];
            return r;
        endfunction

        function trig_result_t divide(longint num, longint dvs);
            trig_result_t r;
            bit [63:0] q;
            if (dvs == 0) begin
                r.value = num < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r.status = ST_DZ;
                return r;
            end
            q = (magnitude(num) << FRAC_BITS) / magnitude(dvs);
            return saturate((num < 0) != (dvs < 0), q);
        endfunction

        // Note an accepted input item
        function void note_input(logic [SEL_W-1:0] sel, logic [ANG_W-1:0] angle);
            bit        neg;
            bit [63:0] a;
            bit [63:0] x2;
            longint    s;
            longint    c;
            longint    one;
            trig_result_t r;
            n_in++;
            n_sel[sel]++;
            if (sel > SEL_CSC) return;
            one = longint'(1) << IP;
            neg = angle[ANG_W-1];
            a = neg ? (64'h10_0000 - angle) : angle;
            x2 = (a * a) >> (2 * ANGLE_FRAC - IP);
            s = taylor_sum(a << (IP - ANGLE_FRAC), x2, 1'b1);
            if (neg) s = -s;
            c = taylor_sum(one, x2, 1'b0);
            case (sel)
                SEL_SIN: r = saturate(s < 0, magnitude(s) >> (IP - FRAC_BITS));
                SEL_COS: r = saturate(c < 0, magnitude(c) >> (IP - FRAC_BITS));
                SEL_TAN: r = divide(s, c);
                SEL_SEC: r = divide(one, c);
                SEL_COT: r = divide(c, s);
                default: r = divide(one, s);
            endcase
            pending.push_back(r);
        endfunction

        // Check one returned item against the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] data);
            trig_result_t want;
            n_out++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d", $time,
                         data[31:0], data[33:32]);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[31:0] !== want.value) begin
                $display("%0t: value mismatch expected %h actual %h", $time,
                         want.value, data[31:0]);
                errors++;
            end
            if (data[33:32] !== want.status) begin
                $display("%0t: status mismatch expected %0d actual %0d", $time,
                         want.status, data[33:32]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [SEL_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    trig_scoreboard sb;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  cycles;

    taylor_trig_function_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // angle[19:0], pad
        .s_tuser  (s_tuser),    // req_type[2:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // value[31:0], status[33:32], pad
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[ANG_W-1:0]);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Drive one angle item, with a random gap in front of it when source idling is enabled
    task automatic send_angle(logic [SEL_W-1:0] sel, logic [ANG_W-1:0] angle);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - ANG_W){1'b0}}, angle};
        s_tuser <= sel;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side back-pressure
    initial begin
        int stall;
        int k;
        m_tready = 1'b0;
        k = 0;
        @(posedge aresetn);
        forever begin
            k++;
            if (k % 150 == 0) sink_idle_on = $urandom_range(0, 3) != 0;
            stall = sink_idle_on ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [ANG_W-1:0] corner[10];
        logic [ANG_W-1:0] ang;
        logic [SEL_W-1:0] fsel;
        int wait_n;
        sb = new();
        cycles = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: range ends, zero, near pi/2 and pi, plus unused selectors
        corner = '{20'h00000, 20'h7FFFF, 20'h80000, 20'hFFFFF, 20'h00001,
                   20'd102944, -20'sd102944, 20'd205887, 20'd102943, 20'd1000};
        for (int i = 0; i < 4; i++)
            for (int f = 0; f <= 5; f++) send_angle(f[SEL_W-1:0], corner[i]);
        send_angle(3'd6, 20'h12345);
        send_angle(3'd7, 20'h54321);
        for (int i = 4; i < 10; i++) send_angle(SEL_W'($urandom_range(0, 5)), corner[i]);

        // Random: mostly principal-range angles, some full range and unused selectors
        for (int i = 0; i < 1500; i++) begin
            if (i % 120 == 0) src_idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) < 6)
                ang = ANG_W'($urandom_range(0, 2 * 209715) - 209715);
            else
                ang = ANG_W'($urandom_range(0, 20'hFFFFF));
            if ($urandom_range(0, 19) == 0)
                fsel = SEL_W'($urandom_range(6, 7));
            else
                fsel = SEL_W'($urandom_range(0, 5));
            send_angle(fsel, ang);
        end
        s_tvalid <= 1'b0;

        // Drain, then give the pipeline its latency once more
        while (sb.pending.size() != 0) @(posedge aclk);
        wait_n = 0;
        while (wait_n < 300) begin
            @(posedge aclk);
            wait_n++;
        end

        $display("%0d items sent (sin %0d cos %0d tan %0d sec %0d cot %0d csc %0d unused %0d)",
                 sb.n_in, sb.n_sel[0], sb.n_sel[1], sb.n_sel[2], sb.n_sel[3],
                 sb.n_sel[4], sb.n_sel[5], sb.n_sel[6] + sb.n_sel[7]);
        $display("%0d results checked, %0d errors", sb.n_out, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ taylor_trig_function_unit.f @@
+incdir+rtl
rtl/ttf_pkg.sv
rtl/ttf_front.sv
rtl/ttf_term.sv
rtl/ttf_div.sv
rtl/taylor_trig_function_unit.sv
rtl/ttf_checker.sv
verif/taylor_trig_function_unit_test.sv
